// ----- rtl/extremum_zero_crossing_detector_defines.svh -----
// Assertion macros shared by the detector's modules.
`ifndef EXTREMUM_ZERO_CROSSING_DETECTOR_DEFINES_SVH
`define EXTREMUM_ZERO_CROSSING_DETECTOR_DEFINES_SVH

`ifndef ASSERT_OFF

`define EZCD_ASSERT(lbl, clk_sig, rst_n_sig, prop, msg) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (prop)) else $error(msg);

`define EZCD_ASSERT_NEVER(lbl, clk_sig, rst_n_sig, prop, msg) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) !(prop)) else $error(msg);

`else

`define EZCD_ASSERT(lbl, clk_sig, rst_n_sig, prop, msg)

`define EZCD_ASSERT_NEVER(lbl, clk_sig, rst_n_sig, prop, msg)

`endif

`endif

// ----- rtl/ezcd_pkg.sv -----
`default_nettype none

package ezcd_pkg;

	localparam int TIME_WIDTH_DEF  = 48;
	localparam int VALUE_WIDTH_DEF = 32;
	localparam int QUEUE_DEPTH     = 4;

	typedef enum logic [1:0] {
		EVT_MAX  = 2'd0,
		EVT_MIN  = 2'd1,
		EVT_UP   = 2'd2,
		EVT_DOWN = 2'd3
	} evt_kind_t;

	typedef struct packed {
		logic has_ext;
		logic ext_min;
		logic has_cross;
		logic up;
	} task_flags_t;

endpackage

`default_nettype wire

// ----- rtl/extremum_zero_crossing_detector.sv -----
// Extremum and zero-crossing detector. Samples (time, value) are taken at up to one item per
// cycle while the four-entry task queue has room; samples that cause no event never enter the
// queue. A sample that causes events queues one task, and the back end turns it into one or two
// event items: an extremum is emitted directly, while a crossing waits on the two bit-serial
// dividers for the interpolated time and the slope, which run side by side. The event output
// is registered, so the next task is worked on while an event waits to be taken.
`default_nettype none

module extremum_zero_crossing_detector #(
	parameter int TIME_WIDTH  = ezcd_pkg::TIME_WIDTH_DEF,
	parameter int VALUE_WIDTH = ezcd_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          sample_valid,
	output logic                               sample_stall,
	input  wire logic        [TIME_WIDTH-1:0]  sample_time,
	input  wire logic signed [VALUE_WIDTH-1:0] sample_value,
	output logic                               event_valid,
	input  wire logic                          event_stall,
	output logic        [1:0]                  event_kind,
	output logic        [TIME_WIDTH-1:0]       event_time,
	output logic signed [VALUE_WIDTH-1:0]      event_value,
	output logic                               last_event
);

	localparam int DATA_W = 2 * TIME_WIDTH + 2 * VALUE_WIDTH;

	logic                  q_full;
	logic                  q_empty;
	logic                  q_push;
	logic                  q_pop;
	ezcd_pkg::task_flags_t push_flags;
	ezcd_pkg::task_flags_t pop_flags;
	logic [DATA_W-1:0]     push_data;
	logic [DATA_W-1:0]     pop_data;

	ezcd_front #(
		.TIME_WIDTH  (TIME_WIDTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample_time  (sample_time),
		.sample_value (sample_value),
		.q_full       (q_full),
		.push         (q_push),
		.push_flags   (push_flags),
		.push_data    (push_data)
	);

	ezcd_queue #(
		.DATA_W (DATA_W)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_flags (push_flags),
		.push_data  (push_data),
		.full       (q_full),
		.pop        (q_pop),
		.pop_flags  (pop_flags),
		.pop_data   (pop_data),
		.empty      (q_empty)
	);

	ezcd_back #(
		.TIME_WIDTH  (TIME_WIDTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.empty       (q_empty),
		.pop         (q_pop),
		.task_flags  (pop_flags),
		.task_data   (pop_data),
		.event_valid (event_valid),
		.event_stall (event_stall),
		.event_kind  (event_kind),
		.event_time  (event_time),
		.event_value (event_value),
		.last_event  (last_event)
	);

endmodule

`default_nettype wire

// ----- rtl/ezcd_queue.sv -----
`default_nettype none

`include "extremum_zero_crossing_detector_defines.svh"

module ezcd_queue #(
	parameter int DATA_W = 160
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire ezcd_pkg::task_flags_t push_flags,
	input  wire logic [DATA_W-1:0]    push_data,
	output logic                      full,
	input  wire logic                 pop,
	output ezcd_pkg::task_flags_t     pop_flags,
	output logic      [DATA_W-1:0]    pop_data,
	output logic                      empty
);

	localparam int DEPTH = ezcd_pkg::QUEUE_DEPTH;
	localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW    = $clog2(DEPTH + 1);

	ezcd_pkg::task_flags_t flags_mem_q [DEPTH];
	logic [DATA_W-1:0]     data_mem_q  [DEPTH];
	logic [PW-1:0]         wr_ptr_q;
	logic [PW-1:0]         rd_ptr_q;
	logic [NW-1:0]         count_q;

	assign full      = (count_q == NW'(DEPTH));
	assign empty     = (count_q == '0);
	assign pop_flags = flags_mem_q[rd_ptr_q];
	assign pop_data  = data_mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			flags_mem_q[wr_ptr_q] <= push_flags;
			data_mem_q[wr_ptr_q]  <= push_data;
		end
	end

	`EZCD_ASSERT_NEVER(a_no_overflow, clk, arst_n, push && full, "task queue overflow")
	`EZCD_ASSERT_NEVER(a_no_underflow, clk, arst_n, pop && empty, "task queue underflow")

endmodule

`default_nettype wire

// ----- rtl/ezcd_front.sv -----
`default_nettype none

module ezcd_front #(
	parameter int TIME_WIDTH  = ezcd_pkg::TIME_WIDTH_DEF,
	parameter int VALUE_WIDTH = ezcd_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  sample_valid,
	output logic                                       sample_stall,
	input  wire logic        [TIME_WIDTH-1:0]          sample_time,
	input  wire logic signed [VALUE_WIDTH-1:0]         sample_value,
	input  wire logic                                  q_full,
	output logic                                       push,
	output ezcd_pkg::task_flags_t                      push_flags,
	output logic [2*TIME_WIDTH+2*VALUE_WIDTH-1:0]      push_data
);

	localparam int TW = TIME_WIDTH;
	localparam int VW = VALUE_WIDTH;

	logic [1:0]    fill_q;
	logic [TW-1:0] older_time_q;
	logic [VW-1:0] older_value_q;
	logic [TW-1:0] middle_time_q;
	logic [VW-1:0] middle_value_q;

	logic accept;
	logic is_max;
	logic is_min;
	logic is_cross;
	logic vo_neg;
	logic vo_pos;
	logic vm_neg;
	logic vm_zero;

	assign sample_stall = q_full;
	assign accept       = sample_valid && !q_full;

	always_comb begin
		is_max  = ($signed(middle_value_q) > $signed(older_value_q)) &&
			($signed(middle_value_q) > sample_value);
		is_min  = ($signed(middle_value_q) < $signed(older_value_q)) &&
			($signed(middle_value_q) < sample_value);
		vo_neg  = older_value_q[VW-1];
		vo_pos  = !older_value_q[VW-1] && (|older_value_q);
		vm_neg  = middle_value_q[VW-1];
		vm_zero = ~|middle_value_q;
		is_cross = (vo_neg && !vm_neg) || (vo_pos && (vm_neg || vm_zero));
	end

	always_comb begin
		push_flags.has_ext   = is_max || is_min;
		push_flags.ext_min   = !is_max;
		push_flags.has_cross = is_cross;
		push_flags.up        = vo_neg;
		push_data = {older_time_q, older_value_q, middle_time_q, middle_value_q};
		push = accept && fill_q[1] && (is_max || is_min || is_cross);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= 2'd0;
		end else if (accept && !fill_q[1]) begin
			fill_q <= fill_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (fill_q == 2'd0) begin
				older_time_q  <= sample_time;
				older_value_q <= sample_value;
			end else if (fill_q == 2'd1) begin
				middle_time_q  <= sample_time;
				middle_value_q <= sample_value;
			end else begin
				older_time_q   <= middle_time_q;
				older_value_q  <= middle_value_q;
				middle_time_q  <= sample_time;
				middle_value_q <= sample_value;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/ezcd_back.sv -----
`default_nettype none

`include "extremum_zero_crossing_detector_defines.svh"

module ezcd_back #(
	parameter int TIME_WIDTH  = ezcd_pkg::TIME_WIDTH_DEF,
	parameter int VALUE_WIDTH = ezcd_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  empty,
	output logic                                       pop,
	input  wire ezcd_pkg::task_flags_t                 task_flags,
	input  wire logic [2*TIME_WIDTH+2*VALUE_WIDTH-1:0] task_data,
	output logic                                       event_valid,
	input  wire logic                                  event_stall,
	output logic        [1:0]                          event_kind,
	output logic        [TIME_WIDTH-1:0]               event_time,
	output logic signed [VALUE_WIDTH-1:0]              event_value,
	output logic                                       last_event
);

	localparam int TW          = TIME_WIDTH;
	localparam int VW          = VALUE_WIDTH;
	localparam int SLOPE_SHIFT = 8;
	localparam int NUM_W       = VW + SLOPE_SHIFT;
	localparam int STEPS       = (TW > NUM_W) ? TW : NUM_W;
	localparam int CW          = $clog2(STEPS);
	localparam logic [NUM_W-1:0] SIGN_Q  = NUM_W'(1) << (VW - 1);
	localparam logic [NUM_W-1:0] MAX_Q   = SIGN_Q - 1'b1;
	localparam logic [VW-1:0]    VAL_MAX = {1'b0, {(VW - 1){1'b1}}};
	localparam logic [VW-1:0]    VAL_MIN = {1'b1, {(VW - 1){1'b0}}};

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_EXT   = 5'b00010,
		ST_SETUP = 5'b00100,
		ST_DIV   = 5'b01000,
		ST_EMIT  = 5'b10000
	} state_t;

	state_t                state_q;
	ezcd_pkg::task_flags_t flags_q;
	logic [TW-1:0]         ot_q;
	logic [VW-1:0]         ov_q;
	logic [TW-1:0]         mt_q;
	logic [VW-1:0]         mv_q;
	logic                  forward_q;
	logic                  dt_zero_q;
	logic [TW-1:0]         dt_q;
	logic [TW-1:0]         a_sh_q;
	logic [VW-1:0]         b_q;
	logic [VW-1:0]         d_q;
	logic [VW-1:0]         acc_q;
	logic [TW-1:0]         mq_q;
	logic [NUM_W-1:0]      num_sh_q;
	logic [TW-1:0]         rem_q;
	logic [NUM_W-1:0]      sq_q;
	logic [CW-1:0]         cnt_q;

	logic                  ev_valid_q;
	ezcd_pkg::evt_kind_t   kind_q;
	logic [TW-1:0]         ev_time_q;
	logic [VW-1:0]         ev_value_q;
	logic                  last_q;

	logic            out_free;
	logic            load_ext;
	logic            load_cross;
	logic            forward;
	logic [TW-1:0]   dt_mag;
	logic [VW-1:0]   vo_mag;
	logic [VW:0]     dv_full;
	logic [VW:0]     dv_neg;
	logic [VW-1:0]   dv_mag;
	logic            mul_act;
	logic            slope_act;
	logic            div_done;
	logic [VW+1:0]   acc2;
	logic [VW+1:0]   d1;
	logic [VW+1:0]   d2;
	logic [VW+1:0]   acc_n;
	logic [1:0]      inc;
	logic [TW:0]     rem2;
	logic            rem_ge;
	logic [TW:0]     rem_n;
	logic [TW-1:0]   cross_time;
	logic [NUM_W-1:0] q_sat;
	logic [VW-1:0]   slope;

	assign pop        = (state_q == ST_IDLE) && !empty;
	assign out_free   = !ev_valid_q || !event_stall;
	assign load_ext   = (state_q == ST_EXT) && out_free;
	assign load_cross = (state_q == ST_EMIT) && out_free;

	always_comb begin
		forward = (mt_q >= ot_q);
		dt_mag  = forward ? (mt_q - ot_q) : (ot_q - mt_q);
		vo_mag  = ov_q[VW-1] ? (~ov_q + 1'b1) : ov_q;
		dv_full = {mv_q[VW-1], mv_q} - {ov_q[VW-1], ov_q};
		dv_neg  = ~dv_full + 1'b1;
		dv_mag  = dv_full[VW] ? dv_neg[VW-1:0] : dv_full[VW-1:0];
	end

	always_comb begin
		mul_act   = (cnt_q >= CW'(STEPS - TW));
		slope_act = (cnt_q >= CW'(STEPS - NUM_W));
		div_done  = (cnt_q == CW'(STEPS - 1));

		acc2 = {1'b0, acc_q, 1'b0} + (a_sh_q[TW-1] ? {2'b00, b_q} : '0);
		d1   = {2'b00, d_q};
		d2   = {1'b0, d_q, 1'b0};
		if (acc2 >= d2) begin
			acc_n = acc2 - d2;
			inc   = 2'd2;
		end else if (acc2 >= d1) begin
			acc_n = acc2 - d1;
			inc   = 2'd1;
		end else begin
			acc_n = acc2;
			inc   = 2'd0;
		end

		rem2   = {rem_q, num_sh_q[NUM_W-1]};
		rem_ge = (rem2 >= {1'b0, dt_q});
		rem_n  = rem_ge ? (rem2 - {1'b0, dt_q}) : rem2;
	end

	always_comb begin
		cross_time = forward_q ? (ot_q + mq_q) : (ot_q - mq_q);
		if (flags_q.up != forward_q) begin
			q_sat = (sq_q > SIGN_Q) ? SIGN_Q : sq_q;
			slope = ~q_sat[VW-1:0] + 1'b1;
		end else begin
			q_sat = (sq_q > MAX_Q) ? MAX_Q : sq_q;
			slope = q_sat[VW-1:0];
		end
		if (dt_zero_q) begin
			slope = flags_q.up ? VAL_MAX : VAL_MIN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			ev_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (!empty) begin
						state_q <= task_flags.has_ext ? ST_EXT : ST_SETUP;
					end
				end
				ST_EXT: begin
					if (out_free) begin
						state_q <= flags_q.has_cross ? ST_SETUP : ST_IDLE;
					end
				end
				ST_SETUP: begin
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (div_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (load_ext || load_cross) begin
				ev_valid_q <= 1'b1;
			end else if (!event_stall) begin
				ev_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			flags_q <= task_flags;
			{ot_q, ov_q, mt_q, mv_q} <= task_data;
		end
		if (state_q == ST_SETUP) begin
			forward_q <= forward;
			dt_zero_q <= (dt_mag == '0);
			dt_q      <= dt_mag;
			a_sh_q    <= dt_mag;
			b_q       <= vo_mag;
			d_q       <= dv_mag;
			acc_q     <= '0;
			mq_q      <= '0;
			num_sh_q  <= {dv_mag, {SLOPE_SHIFT{1'b0}}};
			rem_q     <= '0;
			sq_q      <= '0;
		end
		if (state_q == ST_DIV) begin
			if (mul_act) begin
				a_sh_q <= a_sh_q << 1;
				acc_q  <= acc_n[VW-1:0];
				mq_q   <= {mq_q[TW-2:0], 1'b0} + TW'(inc);
			end
			if (slope_act) begin
				num_sh_q <= num_sh_q << 1;
				rem_q    <= rem_n[TW-1:0];
				sq_q     <= {sq_q[NUM_W-2:0], rem_ge};
			end
		end
		if (load_ext) begin
			kind_q     <= flags_q.ext_min ? ezcd_pkg::EVT_MIN : ezcd_pkg::EVT_MAX;
			ev_time_q  <= mt_q;
			ev_value_q <= mv_q;
			last_q     <= !flags_q.has_cross;
		end else if (load_cross) begin
			kind_q     <= flags_q.up ? ezcd_pkg::EVT_UP : ezcd_pkg::EVT_DOWN;
			ev_time_q  <= cross_time;
			ev_value_q <= slope;
			last_q     <= 1'b1;
		end
	end

	assign event_valid = ev_valid_q;
	assign event_kind  = kind_q;
	assign event_time  = ev_time_q;
	assign event_value = ev_value_q;
	assign last_event  = last_q;

	`EZCD_ASSERT(a_cross_is_last, clk, arst_n, ev_valid_q && (kind_q == ezcd_pkg::EVT_UP || kind_q == ezcd_pkg::EVT_DOWN) |-> last_q, "crossing event not marked last")
	`EZCD_ASSERT(a_pop_when_idle, clk, arst_n, pop |-> (state_q == ST_IDLE), "task taken while busy")

endmodule

`default_nettype wire
